FILE: design/dcpp_pkg.sv
// Shared definitions for the delimited command packet parser.
// Event codes, parse states, configuration indexes and field widths.
// No dependencies.
package dcpp_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int EV_W    = 3;
    localparam int LEN_W   = 6;
    localparam int CFG_A_W = 2;

    // Default limit on parameter length
    localparam int MAX_PARAM_LEN_DEF = 32;

    // Result event codes
    localparam logic [EV_W-1:0] EV_PROGRESS = 3'd0;
    localparam logic [EV_W-1:0] EV_COMMAND  = 3'd1;
    localparam logic [EV_W-1:0] EV_PARAM    = 3'd2;
    localparam logic [EV_W-1:0] EV_EMPTY    = 3'd3;
    localparam logic [EV_W-1:0] EV_EOP      = 3'd4;
    localparam logic [EV_W-1:0] EV_CORRUPT  = 3'd5;
    localparam logic [EV_W-1:0] EV_TOOLONG  = 3'd6;

    // Parse states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CMD   = 2'd1;
    localparam logic [1:0] ST_PARAM = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_START = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_END   = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_DELIM = 2'd2;

    // Reset values of the configuration registers
    localparam logic [BYTE_W-1:0] START_RST = 8'd60;
    localparam logic [BYTE_W-1:0] END_RST   = 8'd62;
    localparam logic [BYTE_W-1:0] DELIM_RST = 8'd44;

endpackage

FILE: design/delimited_command_packet_parser_core.sv
// Delimited command packet parser: start byte, command byte, delimited parameters, end byte.
// A byte waits in an input register until the run sequencer is idle and the output register
// is free, then is decoded; no new byte is taken until then. A run reads each parameter byte
// from the RAM, then loads it to the output register; end of packet follows a run closed by
// the end byte. Reset (synchronous, active low) clears control state and loads the default
// delimiters; the parameter RAM is not cleared.
module delimited_command_packet_parser_core
    import dcpp_pkg::*;
#(
    parameter int MAX_PARAM_LEN = MAX_PARAM_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
    // Result stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [15:0]        m_axis_tdata,   // [7:0] data_byte, [13:8] param_length, pad
    output logic [EV_W-1:0]    m_axis_tuser,   // [2:0] event_res
    output logic               m_axis_tlast,   // last result for this input byte
    // Configuration writes
    input  logic               i_cfg_we,
    input  logic [CFG_A_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]  i_cfg_data
);

    localparam int AW = (MAX_PARAM_LEN > 1) ? $clog2(MAX_PARAM_LEN) : 1;
    localparam int CW = $clog2(MAX_PARAM_LEN + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PARAM_LEN);

    // Sequencer codes
    localparam logic [1:0] SEQ_IDLE = 2'd0;
    localparam logic [1:0] SEQ_RD   = 2'd1;
    localparam logic [1:0] SEQ_WR   = 2'd2;
    localparam logic [1:0] SEQ_EOP  = 2'd3;

    // Configuration
    logic [BYTE_W-1:0] r_start, r_end, r_delim;

    // Input register
    logic              r_in_valid, n_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // Parser and sequencer state
    logic [1:0]        r_pst, n_pst;
    logic [1:0]        r_seq, n_seq;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_len, n_len;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_eop, n_eop;

    // Output register
    logic              r_out_valid, n_out_valid;
    logic [EV_W-1:0]   r_out_ev, n_out_ev;
    logic [BYTE_W-1:0] r_out_data, n_out_data;
    logic [LEN_W-1:0]  r_out_len, n_out_len;
    logic              r_out_last, n_out_last;

    // RAM port signals
    logic              ram_we;
    logic [BYTE_W-1:0] ram_rdata;

    logic              out_free;
    logic              last_idx;
    logic              in_take;

    assign out_free = !r_out_valid || m_axis_tready;
    assign last_idx = (CW'(r_idx + 1'b1) == r_len);
    assign in_take  = s_axis_tvalid && !r_in_valid;

    // Parameter byte store
    dcpp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PARAM_LEN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_in_byte),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Decode the held byte and drive the run sequencer
    always_comb begin
        n_in_valid  = r_in_valid;
        n_pst       = r_pst;
        n_seq       = r_seq;
        n_count     = r_count;
        n_len       = r_len;
        n_idx       = r_idx;
        n_eop       = r_eop;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_ev    = r_out_ev;
        n_out_data  = r_out_data;
        n_out_len   = r_out_len;
        n_out_last  = r_out_last;
        ram_we      = 1'b0;

        unique case (r_seq)
            SEQ_IDLE: begin
                if (r_in_valid && out_free) begin
                    n_in_valid  = 1'b0;
                    n_out_valid = 1'b1;
                    n_out_ev    = EV_PROGRESS;
                    n_out_data  = '0;
                    n_out_len   = '0;
                    n_out_last  = 1'b1;
                    priority if (r_in_byte == r_start) begin
                        if (r_pst == ST_CMD || r_pst == ST_PARAM) begin
                            n_out_ev = EV_CORRUPT;
                        end
                        n_count = '0;
                        n_pst   = ST_CMD;
                    end else if (r_in_byte == r_end) begin
                        n_pst = ST_IDLE;
                        if (r_pst == ST_PARAM) begin
                            if (r_count == '0) begin
                                n_out_ev = EV_EOP;
                            end else begin
                                // start a run, end of packet follows it
                                n_out_valid = r_out_valid && !m_axis_tready;
                                n_len       = r_count;
                                n_idx       = '0;
                                n_eop       = 1'b1;
                                n_count     = '0;
                                n_seq       = SEQ_RD;
                            end
                        end else if (r_pst == ST_CMD) begin
                            n_out_ev = EV_CORRUPT;
                            n_count  = '0;
                        end
                    end else if (r_in_byte == r_delim) begin
                        if (r_pst == ST_PARAM) begin
                            if (r_count == '0) begin
                                n_out_ev = EV_EMPTY;
                            end else begin
                                n_out_valid = r_out_valid && !m_axis_tready;
                                n_len       = r_count;
                                n_idx       = '0;
                                n_eop       = 1'b0;
                                n_count     = '0;
                                n_seq       = SEQ_RD;
                            end
                        end else if (r_pst == ST_CMD) begin
                            n_out_ev = EV_CORRUPT;
                            n_count  = '0;
                            n_pst    = ST_IDLE;
                        end else begin
                            n_pst = ST_IDLE;
                        end
                    end else begin
                        if (r_pst == ST_CMD) begin
                            n_out_ev   = EV_COMMAND;
                            n_out_data = r_in_byte;
                            n_count    = '0;
                            n_pst      = ST_PARAM;
                        end else if (r_pst == ST_PARAM) begin
                            if (r_count >= MAX_CNT) begin
                                n_out_ev = EV_TOOLONG;
                                n_count  = '0;
                                n_pst    = ST_IDLE;
                            end else begin
                                // store the byte, report progress
                                ram_we  = 1'b1;
                                n_count = CW'(r_count + 1'b1);
                            end
                        end else begin
                            n_pst = ST_IDLE;
                        end
                    end
                end
            end
            SEQ_RD: begin
                // address is on the RAM, data lands next cycle
                n_seq = SEQ_WR;
            end
            SEQ_WR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ev    = EV_PARAM;
                    n_out_data  = ram_rdata;
                    n_out_len   = LEN_W'(r_len);
                    n_out_last  = last_idx && !r_eop;
                    if (last_idx) begin
                        n_seq = r_eop ? SEQ_EOP : SEQ_IDLE;
                    end else begin
                        n_idx = CW'(r_idx + 1'b1);
                        n_seq = SEQ_RD;
                    end
                end
            end
            SEQ_EOP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ev    = EV_EOP;
                    n_out_data  = '0;
                    n_out_len   = '0;
                    n_out_last  = 1'b1;
                    n_seq       = SEQ_IDLE;
                end
            end
            default: begin
                n_seq = SEQ_IDLE;
            end
        endcase

        // take a new beat into the empty input register
        if (in_take) begin
            n_in_valid = 1'b1;
        end
    end

    // Control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= START_RST;
            r_end       <= END_RST;
            r_delim     <= DELIM_RST;
            r_in_valid  <= 1'b0;
            r_pst       <= ST_IDLE;
            r_seq       <= SEQ_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_START: r_start <= i_cfg_data;
                    CFG_END:   r_end   <= i_cfg_data;
                    CFG_DELIM: r_delim <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_in_valid  <= n_in_valid;
            r_pst       <= n_pst;
            r_seq       <= n_seq;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= s_axis_tdata;
        end
        r_len      <= n_len;
        r_idx      <= n_idx;
        r_eop      <= n_eop;
        r_out_ev   <= n_out_ev;
        r_out_data <= n_out_data;
        r_out_len  <= n_out_len;
        r_out_last <= n_out_last;
    end

    assign s_axis_tready = !r_in_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_len, r_out_data};
    assign m_axis_tuser  = r_out_ev;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    // Parameter fill never passes the limit
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("parameter count above limit");

    // Run index stays inside the captured length
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == SEQ_RD || r_seq == SEQ_WR) |-> (r_idx < r_len))
        else $error("run index out of range");

    // Output load of a run byte only follows a RAM read cycle or a stalled output load
    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == SEQ_WR) |-> ($past(r_seq) == SEQ_RD || $past(r_seq) == SEQ_WR))
        else $error("run write without preceding read");

    // Store writes happen only inside a parameter with room left
    a_store_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_pst == ST_PARAM && r_count < MAX_CNT && r_seq == SEQ_IDLE))
        else $error("unexpected parameter store write");
`endif

endmodule

FILE: design/dcpp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the parameter byte store of the packet parser. No dependencies.
module dcpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: dv/testbench.sv
// Self-checking bench for delimited_command_packet_parser_core: framed byte traffic in,
// parse events out, compared against a cycle-free predictor of the parser.
// Depends on dcpp_pkg, the core RTL and dcpp_ram only.
`timescale 1ns / 1ps

module testbench;
    import dcpp_pkg::*;

    localparam int PARAM_LIMIT  = MAX_PARAM_LEN_DEF;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 6;

    typedef struct packed {
        logic [EV_W-1:0]  ev;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
        logic             last;
    } t_parse_result;

    typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_BURSTY} t_ready_mode;

    // DUT connections; the inputs driven by the bench are known from time zero
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [15:0]        m_axis_tdata;
    logic [EV_W-1:0]    m_axis_tuser;
    logic               m_axis_tlast;
    logic               i_cfg_we      = 1'b0;
    logic [CFG_A_W-1:0] i_cfg_idx     = CFG_START;
    logic [BYTE_W-1:0]  i_cfg_data    = '0;

    // Predictor copy of the delimiter registers and parse state
    logic [7:0] cfg_start = START_RST;
    logic [7:0] cfg_end   = END_RST;
    logic [7:0] cfg_delim = DELIM_RST;
    logic [1:0] parse_st  = ST_IDLE;
    logic [7:0] param_mem [PARAM_LIMIT];
    int         param_cnt = 0;

    logic [7:0]    rx_bytes_queued [$];
    t_parse_result parse_results_due [$];

    int errors        = 0;
    int bytes_sent    = 0;
    int bytes_framed  = 0;
    int results_seen  = 0;
    int settings_used = 1;
    int cycles        = 0;

    // Sender and receiver pacing
    int          burst_left = 1;
    int          gap_left   = 0;
    int          stall_left = 0;
    int          mode_left  = 0;
    t_ready_mode rx_mode    = RDY_ALWAYS;

    delimited_command_packet_parser_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] rx_byte
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] data_byte, [13:8] param_length, pad
        .m_axis_tuser  (m_axis_tuser),   // [2:0] event_res
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void due_result(logic [EV_W-1:0] ev, logic [7:0] data, int len);
        t_parse_result r;
        r.ev   = ev;
        r.data = data;
        r.len  = LEN_W'(len);
        r.last = 1'b0;
        parse_results_due.push_back(r);
    endfunction

    // Flush the parameter in progress as a run of byte events
    function automatic void due_param_run();
        for (int i = 0; i < param_cnt; i++)
            due_result(EV_PARAM, param_mem[i], param_cnt);
        param_cnt = 0;
    endfunction

    // Work out every event one received byte causes; start beats end beats delimiter
    function automatic void parse_rx_byte(logic [7:0] b);
        if (b == cfg_start) begin
            due_result((parse_st == ST_IDLE) ? EV_PROGRESS : EV_CORRUPT, '0, 0);
            param_cnt = 0;
            parse_st  = ST_CMD;
        end else if (b == cfg_end) begin
            if (parse_st == ST_PARAM) begin
                due_param_run();
                due_result(EV_EOP, '0, 0);
            end else if (parse_st == ST_CMD) begin
                due_result(EV_CORRUPT, '0, 0);
                param_cnt = 0;
            end else begin
                due_result(EV_PROGRESS, '0, 0);
            end
            parse_st = ST_IDLE;
        end else if (b == cfg_delim) begin
            if (parse_st == ST_PARAM) begin
                if (param_cnt == 0)
                    due_result(EV_EMPTY, '0, 0);
                else
                    due_param_run();
            end else if (parse_st == ST_CMD) begin
                due_result(EV_CORRUPT, '0, 0);
                param_cnt = 0;
                parse_st  = ST_IDLE;
            end else begin
                due_result(EV_PROGRESS, '0, 0);
                parse_st = ST_IDLE;
            end
        end else if (parse_st == ST_CMD) begin
            due_result(EV_COMMAND, b, 0);
            param_cnt = 0;
            parse_st  = ST_PARAM;
        end else if (parse_st == ST_PARAM) begin
            if (param_cnt >= PARAM_LIMIT) begin
                due_result(EV_TOOLONG, '0, 0);
                param_cnt = 0;
                parse_st  = ST_IDLE;
            end else begin
                param_mem[param_cnt] = b;
                param_cnt++;
                due_result(EV_PROGRESS, '0, 0);
            end
        end else begin
            due_result(EV_PROGRESS, '0, 0);
            parse_st = ST_IDLE;
        end
        parse_results_due[parse_results_due.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------- driver

    // Launch queued bytes in bursts; hold a beat until it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                parse_rx_byte(s_axis_tdata);
                bytes_sent++;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (rx_bytes_queued.size() != 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= rx_bytes_queued.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    // Switch between steady, coin-flip and bursty back-pressure every so often
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            rx_mode   = t_ready_mode'($urandom_range(0, 2));
            mode_left = $urandom_range(40, 120);
        end else begin
            mode_left--;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RDY_ALWAYS: begin
                    m_axis_tready <= 1'b1;
                end
                RDY_COIN: begin
                    m_axis_tready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    m_axis_tready <= 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        stall_left = $urandom_range(1, 6);
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- monitor

    function automatic void flag_error(string msg);
        errors++;
        if (errors <= 10)
            $display("MISMATCH: %s", msg);
    endfunction

    // Compare each accepted event beat against the oldest one due
    always @(posedge i_clk) begin
        t_parse_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (parse_results_due.size() == 0) begin
                flag_error($sformatf("beat %0d with nothing due: event %0d data %02h len %0d",
                                     results_seen, m_axis_tuser, m_axis_tdata[7:0],
                                     m_axis_tdata[13:8]));
            end else begin
                want = parse_results_due.pop_front();
                if (m_axis_tuser !== want.ev)
                    flag_error($sformatf("beat %0d event: expected %0d, got %0d",
                                         results_seen, want.ev, m_axis_tuser));
                if (m_axis_tdata[7:0] !== want.data)
                    flag_error($sformatf("beat %0d data_byte: expected %02h, got %02h",
                                         results_seen, want.data, m_axis_tdata[7:0]));
                if (m_axis_tdata[13:8] !== want.len)
                    flag_error($sformatf("beat %0d param_length: expected %0d, got %0d",
                                         results_seen, want.len, m_axis_tdata[13:8]));
                if (m_axis_tdata[15:14] !== 2'b00)
                    flag_error($sformatf("beat %0d pad bits: expected 0, got %0d",
                                         results_seen, m_axis_tdata[15:14]));
                if (m_axis_tlast !== want.last)
                    flag_error($sformatf("beat %0d last: expected %0d, got %0d",
                                         results_seen, want.last, m_axis_tlast));
            end
        end
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d events still due",
                     cycles, parse_results_due.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic void queue_byte(logic [7:0] b);
        rx_bytes_queued.push_back(b);
        bytes_framed++;
    endfunction

    // Random byte that matches none of the framing registers
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == cfg_start || b == cfg_end || b == cfg_delim);
        return b;
    endfunction

    // Mostly short parameters, some full-size ones, a few one past the limit
    function automatic int pick_param_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return $urandom_range(1, 6);
        if (r < 70) return 0;
        if (r < 87) return $urandom_range(7, PARAM_LIMIT - 1);
        if (r < 95) return PARAM_LIMIT;
        return PARAM_LIMIT + 1;
    endfunction

    // Well-formed frame with random content; first_len < 0 picks the first length too
    function automatic void queue_frame(int first_len);
        int n_params;
        int len;
        n_params = $urandom_range((first_len >= 0) ? 1 : 0, 3);
        queue_byte(cfg_start);
        queue_byte(plain_byte());
        for (int i = 0; i < n_params; i++) begin
            len = (i == 0 && first_len >= 0) ? first_len : pick_param_len();
            for (int j = 0; j < len; j++)
                queue_byte(plain_byte());
            if (i != n_params - 1 || $urandom_range(0, 3) == 0)
                queue_byte(cfg_delim);
        end
        queue_byte(cfg_end);
    endfunction

    // Frame cut short or interrupted by a framing byte
    function automatic void queue_broken_frame();
        int len;
        queue_byte(cfg_start);
        case ($urandom_range(0, 3))
            0: queue_byte(cfg_start);
            1: queue_byte(cfg_end);
            2: queue_byte(cfg_delim);
            default: begin
                queue_byte(plain_byte());
                len = $urandom_range(0, 5);
                for (int j = 0; j < len; j++)
                    queue_byte(plain_byte());
                queue_byte(cfg_start);
            end
        endcase
    endfunction

    // Mostly good frames, some broken ones, a little loose noise
    function automatic void queue_traffic(int n_bytes);
        int goal;
        int r;
        goal = bytes_framed + n_bytes;
        while (bytes_framed < goal) begin
            r = $urandom_range(0, 99);
            if (r < 72)
                queue_frame(-1);
            else if (r < 88)
                queue_broken_frame();
            else
                queue_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    // Hold off until the sender is empty and every due event has arrived
    task automatic wait_drained();
        while (rx_bytes_queued.size() != 0 || s_axis_tvalid || parse_results_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_START: cfg_start = val;
            CFG_END:   cfg_end   = val;
            default:   cfg_delim = val;
        endcase
    endtask

    task automatic set_framing(input logic [7:0] s, input logic [7:0] e, input logic [7:0] d);
        wait_drained();
        write_reg(CFG_START, s);
        write_reg(CFG_END, e);
        write_reg(CFG_DELIM, d);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames on the reset framing: params, empty params, stray bytes
        queue_byte(cfg_start); queue_byte(8'h41); queue_byte(8'h78); queue_byte(8'h79);
        queue_byte(cfg_delim); queue_byte(cfg_delim); queue_byte(cfg_end);
        queue_byte(8'h00); queue_byte(8'hFF); queue_byte(cfg_end); queue_byte(cfg_delim);
        // restart inside a frame, framing byte where the command belongs
        queue_byte(cfg_start); queue_byte(cfg_start); queue_byte(cfg_end);
        queue_byte(cfg_start); queue_byte(cfg_delim);
        queue_byte(cfg_start); queue_byte(8'h00); queue_byte(8'hFF); queue_byte(cfg_end);
        queue_byte(cfg_start); queue_byte(8'h7F); queue_byte(8'h80); queue_byte(cfg_delim);
        queue_byte(cfg_end);
        // full-size parameter, then one byte too many
        queue_frame(PARAM_LIMIT);
        queue_frame(PARAM_LIMIT + 1);
        queue_traffic(30);

        // Extreme framing values
        set_framing(8'h00, 8'hFF, 8'h80);
        queue_traffic(25);
        set_framing(8'hFF, 8'h00, 8'h01);
        queue_traffic(20);

        // Overlapping registers: end over delimiter, start over delimiter
        set_framing(8'h10, 8'h20, 8'h20);
        queue_traffic(20);
        set_framing(8'hFF, 8'h40, 8'hFF);
        queue_traffic(15);

        // Distinct framing values
        set_framing(8'h3C, 8'hC3, 8'h5A);
        queue_traffic(20);

        wait_drained();
        $display("covered %0d bytes over %0d framing settings, %0d event beats checked",
                 bytes_sent, settings_used, results_seen);
        $display("frames, broken frames, empty and full-size params, overflow, noise");
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches counted", errors);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
